// File: rtl/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; expects a clock named clk and a reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define CHK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked on every rising clock edge outside reset
`define CHK_IMPLY(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication checked outside reset
`define CHK_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// File: rtl/lrf_pkg.sv
// types, constants and helpers for the line receive ring fifo
// used by every rtl file of the block except lrf_ram; no dependencies
package lrf_pkg;

  localparam int DEPTH    = 64;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int MAX_LINE = 64;
  localparam int LEN_W    = 7;
  localparam int CMP_W    = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  localparam logic [7:0] NEWLINE = 8'h0A;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_LINE  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] in_byte;
    logic [6:0] line_room;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic [6:0] line_length;
    logic       dropped;
    logic       is_empty;
    logic       is_full;
    logic [6:0] fill_count;
  } result_t;

  typedef struct packed {
    logic latch;
    logic load_simple;
    logic pop_issue;
    logic pop_put;
    logic scan_start;
    logic scan_step;
    logic decide;
    logic line_rd;
    logic line_put;
  } cmd_t;

  typedef struct packed {
    action_t action;
    logic    held_zero;
    logic    lim_zero;
    logic    scan_done;
    logic    ready;
    logic    emit_last;
    logic    out_free;
  } sts_t;

  function automatic logic [ADDR_W-1:0] pos_inc(input logic [ADDR_W-1:0] p);
    pos_inc = (p == ADDR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

// File: rtl/lrf_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module lrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/lrf_datapath.sv
// datapath: byte store, positions, count, line scan and emit counters, result register
// depends on lrf_pkg and lrf_ram
module lrf_datapath (
  input  logic             clk,
  input  logic             rst,
  input  lrf_pkg::item_t   item,
  input  lrf_pkg::cmd_t    cmd,
  output lrf_pkg::sts_t    sts,
  output logic             result_valid,
  input  logic             result_stall,
  output lrf_pkg::result_t result
);
  import lrf_pkg::*;

  item_t             cur;
  logic [ADDR_W-1:0] wpos, wpos_next;
  logic [ADDR_W-1:0] rpos, rpos_next;
  logic [CNT_W-1:0]  held, held_next;

  logic [ADDR_W-1:0] scan_addr, scan_addr_next;
  logic [CNT_W-1:0]  scan_left, scan_left_next;
  logic              chk_pend, chk_pend_next;
  logic [CNT_W-1:0]  chk_idx, chk_idx_next;
  logic              nl_found, nl_found_next;
  logic [CNT_W-1:0]  nl_off, nl_off_next;

  logic [LEN_W-1:0]  emit_total, emit_total_next;
  logic [LEN_W-1:0]  emit_cons, emit_cons_next;
  logic [LEN_W-1:0]  emit_idx, emit_idx_next;
  logic              emit_dry, emit_dry_next;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  logic [6:0]        room_m1;
  logic [LEN_W-1:0]  limit;
  logic [CMP_W-1:0]  nl_off_x, lim_x, held_x, total_x, cons_x;
  logic              load;
  result_t           res_next;
  logic              emit_last;

  lrf_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // line limit: room - 1 (zero for no room), saturated at the longest line
  assign room_m1 = cur.line_room - 7'd1;
  assign limit   = (cur.line_room == 7'd0) ? '0 :
                   (room_m1 > 7'(MAX_LINE)) ? LEN_W'(MAX_LINE) : LEN_W'(room_m1);

  assign nl_off_x = CMP_W'(nl_off);
  assign lim_x    = CMP_W'(limit);
  assign held_x   = CMP_W'(held);
  assign total_x  = (nl_found && (nl_off_x < lim_x)) ? nl_off_x + 1'b1 : lim_x;
  assign cons_x   = (total_x < held_x) ? total_x : held_x;

  assign emit_last = ((emit_idx + LEN_W'(1)) == emit_total);

  always_comb begin
    wpos_next       = wpos;
    rpos_next       = rpos;
    held_next       = held;
    scan_addr_next  = scan_addr;
    scan_left_next  = scan_left;
    chk_pend_next   = chk_pend;
    chk_idx_next    = chk_idx;
    nl_found_next   = nl_found;
    nl_off_next     = nl_off;
    emit_total_next = emit_total;
    emit_cons_next  = emit_cons;
    emit_idx_next   = emit_idx;
    emit_dry_next   = emit_dry;
    ram_we          = 1'b0;
    ram_waddr       = wpos;
    ram_wdata       = cur.in_byte;
    ram_re          = 1'b0;
    ram_raddr       = rpos;
    load            = 1'b0;
    res_next        = '0;
    res_next.last   = 1'b1;

    if (cmd.load_simple) begin
      load = 1'b1;
      case (cur.action)
        ACT_PUSH: begin
          if (held != CNT_W'(DEPTH)) begin
            ram_we    = 1'b1;
            wpos_next = pos_inc(wpos);
            held_next = held + 1'b1;
          end else begin
            res_next.dropped = 1'b1;
          end
        end
        ACT_CLEAR: begin
          wpos_next = '0;
          rpos_next = '0;
          held_next = '0;
        end
        default: begin
        end
      endcase
    end

    if (cmd.pop_issue) begin
      ram_re    = 1'b1;
      rpos_next = pos_inc(rpos);
      held_next = held - 1'b1;
    end

    if (cmd.pop_put) begin
      load                = 1'b1;
      res_next.out_byte   = ram_rdata;
      res_next.byte_valid = 1'b1;
    end

    if (cmd.scan_start) begin
      scan_addr_next = rpos;
      scan_left_next = held;
      chk_pend_next  = 1'b0;
      chk_idx_next   = '0;
      nl_found_next  = 1'b0;
      nl_off_next    = '0;
    end

    if (cmd.scan_step) begin
      if (scan_left != '0) begin
        ram_re         = 1'b1;
        ram_raddr      = scan_addr;
        scan_addr_next = pos_inc(scan_addr);
        scan_left_next = scan_left - 1'b1;
      end
      chk_pend_next = (scan_left != '0);
      if (chk_pend) begin
        chk_idx_next = chk_idx + 1'b1;
        if ((ram_rdata == NEWLINE) && !nl_found) begin
          nl_found_next = 1'b1;
          nl_off_next   = chk_idx;
        end
      end
    end

    if (cmd.decide) begin
      emit_total_next = LEN_W'(total_x);
      emit_cons_next  = LEN_W'(cons_x);
      emit_idx_next   = '0;
      held_next       = held - CNT_W'(cons_x);
    end

    if (cmd.line_rd) begin
      emit_dry_next = (emit_idx >= emit_cons);
      if (emit_idx < emit_cons) begin
        ram_re    = 1'b1;
        rpos_next = pos_inc(rpos);
      end
    end

    if (cmd.line_put) begin
      load                 = 1'b1;
      res_next.out_byte    = emit_dry ? 8'h00 : ram_rdata;
      res_next.byte_valid  = 1'b1;
      res_next.last        = emit_last;
      res_next.line_length = emit_last ? 7'(emit_total) : 7'd0;
      emit_idx_next        = emit_idx + 1'b1;
    end

    res_next.is_empty   = (held_next == '0);
    res_next.is_full    = (held_next == CNT_W'(DEPTH));
    res_next.fill_count = 7'(held_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wpos         <= '0;
      rpos         <= '0;
      held         <= '0;
      chk_pend     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      wpos     <= wpos_next;
      rpos     <= rpos_next;
      held     <= held_next;
      chk_pend <= chk_pend_next;
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cur <= item;
    end
    if (load) begin
      result <= res_next;
    end
    scan_addr  <= scan_addr_next;
    scan_left  <= scan_left_next;
    chk_idx    <= chk_idx_next;
    nl_found   <= nl_found_next;
    nl_off     <= nl_off_next;
    emit_total <= emit_total_next;
    emit_cons  <= emit_cons_next;
    emit_idx   <= emit_idx_next;
    emit_dry   <= emit_dry_next;
  end

  assign sts.action    = cur.action;
  assign sts.held_zero = (held == '0);
  assign sts.lim_zero  = (limit == '0);
  assign sts.scan_done = (scan_left == '0) && !chk_pend;
  assign sts.ready     = nl_found || (held == CNT_W'(DEPTH));
  assign sts.emit_last = emit_last;
  assign sts.out_free  = !result_valid || !result_stall;

endmodule

// File: rtl/lrf_ctrl.sv
// controller state machine: sequences push, pop, clear, line scan and line emit
// depends on lrf_pkg
module lrf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  input  lrf_pkg::sts_t sts,
  output lrf_pkg::cmd_t cmd
);
  import lrf_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_EXEC     = 7'b0000010,
    S_POP_PUT  = 7'b0000100,
    S_SCAN     = 7'b0001000,
    S_DECIDE   = 7'b0010000,
    S_LINE_RD  = 7'b0100000,
    S_LINE_PUT = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.action)
          ACT_POP: begin
            if (!sts.held_zero) begin
              cmd.pop_issue = 1'b1;
              state_next    = S_POP_PUT;
            end else if (sts.out_free) begin
              cmd.load_simple = 1'b1;
              state_next      = S_IDLE;
            end
          end
          ACT_LINE: begin
            if (!sts.held_zero && !sts.lim_zero) begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end else if (sts.out_free) begin
              cmd.load_simple = 1'b1;
              state_next      = S_IDLE;
            end
          end
          default: begin
            if (sts.out_free) begin
              cmd.load_simple = 1'b1;
              state_next      = S_IDLE;
            end
          end
        endcase
      end
      S_POP_PUT: begin
        if (sts.out_free) begin
          cmd.pop_put = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.ready) begin
          cmd.decide = 1'b1;
          state_next = S_LINE_RD;
        end else if (sts.out_free) begin
          cmd.load_simple = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_LINE_RD: begin
        cmd.line_rd = 1'b1;
        state_next  = S_LINE_PUT;
      end
      S_LINE_PUT: begin
        if (sts.out_free) begin
          cmd.line_put = 1'b1;
          state_next   = sts.emit_last ? S_IDLE : S_LINE_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign item_stall = (state != S_IDLE);

endmodule

// File: rtl/line_receive_ring_fifo.sv
// Receive byte ring fifo with push, pop, line read and clear, one item at a time.
// A push, clear or pop of an empty store loads its result in the execute state, a pop
// of a held byte after its ram read. A line read first scans every held byte through the
// single ram read port, then emits its bytes one at a time via the registered ram read.
// A line read that finds no newline, with the store not full, gives its single result in
// the decide state after the scan; with an empty store or a room below two it skips the
// scan and answers like a push. A new item is taken the cycle after the previous one has
// placed its last result in the output register. A stalled output holds the block only
// where it must load the next result; the scan runs on.
// depends on lrf_pkg, lrf_ctrl and lrf_datapath
module line_receive_ring_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  lrf_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output lrf_pkg::result_t result
);
  import lrf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lrf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  lrf_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// File: rtl/lrf_checker.sv
// port-level checker for the line receive ring fifo, bound to the top level
// depends on lrf_pkg and assert_macros.svh
`include "assert_macros.svh"

module lrf_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_stall,
  input lrf_pkg::item_t   item,
  input logic             result_valid,
  input logic             result_stall,
  input lrf_pkg::result_t result
);
  import lrf_pkg::*;

  logic [1:0] outstanding;
  logic       item_take;
  logic       last_take;

  assign item_take = item_valid && !item_stall;
  assign last_take = result_valid && !result_stall && result.last;

  // transactions whose last result is not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + {1'b0, item_take} - {1'b0, last_take};
    end
  end

  `CHK_NEXT(a_result_hold, result_valid && result_stall,
            result_valid && $stable(result), "stalled result changed")
  `CHK_IMPLY(a_no_orphan, result_valid, outstanding != 2'd0,
             "result without an accepted transaction")
  `CHK_IMPLY(a_one_ahead, item_take, outstanding <= 2'd1,
             "item taken with two transactions open")
  `CHK_IMPLY(a_drop_full, result_valid && result.dropped,
             result.is_full && !result.byte_valid && (result.fill_count == 7'(DEPTH)),
             "drop flagged while store not full")

endmodule

bind line_receive_ring_fifo lrf_checker u_lrf_checker (.*);

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for line_receive_ring_fifo: directed and random transactions,
// a scoreboard class that mirrors the ring store, random idling on both channels
// depends on lrf_pkg and the line_receive_ring_fifo rtl
module testbench;
  import lrf_pkg::*;

  class ring_mirror;
    logic [7:0] mem [DEPTH];
    int unsigned wr_pos;
    int unsigned rd_pos;
    int unsigned held;
    result_t due_results[$];
    int errors;

    function new();
      wr_pos = 0;
      rd_pos = 0;
      held = 0;
      errors = 0;
    endfunction

    function logic [7:0] take_byte();
      take_byte = 8'h00;
      if (held > 0) begin
        if (rd_pos >= DEPTH) rd_pos = 0;
        take_byte = mem[rd_pos];
        rd_pos++;
        held--;
      end
    endfunction

    function bit has_newline();
      int unsigned n;
      int unsigned p;
      n = held;
      p = rd_pos;
      has_newline = 0;
      while (n > 0) begin
        if (p >= DEPTH) p = 0;
        if (mem[p] == NEWLINE) has_newline = 1;
        p++;
        n--;
      end
    endfunction

    // work out every result of one accepted transaction and queue them
    function void accept_item(item_t it);
      result_t r;
      result_t burst[$];
      int unsigned limit;
      int unsigned n;
      logic [7:0] b;
      bit ready;
      r = '0;
      r.last = 1'b1;
      case (it.action)
        ACT_PUSH: begin
          if (held < DEPTH) begin
            if (wr_pos >= DEPTH) wr_pos = 0;
            mem[wr_pos] = it.in_byte;
            wr_pos++;
            held++;
          end else begin
            r.dropped = 1'b1;
          end
          burst.push_back(r);
        end
        ACT_POP: begin
          if (held > 0) begin
            r.out_byte = take_byte();
            r.byte_valid = 1'b1;
          end
          burst.push_back(r);
        end
        ACT_LINE: begin
          ready = held > 0 && (has_newline() || held == DEPTH);
          limit = it.line_room > 0 ? it.line_room - 1 : 0;
          if (limit > MAX_LINE) limit = MAX_LINE;
          if (!ready || limit == 0) begin
            burst.push_back(r);
          end else begin
            n = 0;
            while (n < limit) begin
              b = take_byte();
              r = '0;
              r.out_byte = b;
              r.byte_valid = 1'b1;
              burst.push_back(r);
              n++;
              if (b == NEWLINE) break;
            end
            r = burst.pop_back();
            r.last = 1'b1;
            r.line_length = 7'(n);
            burst.push_back(r);
          end
        end
        default: begin
          held = 0;
          wr_pos = 0;
          rd_pos = 0;
          burst.push_back(r);
        end
      endcase
      foreach (burst[k]) begin
        r = burst[k];
        r.is_empty = held == 0;
        r.is_full = held == DEPTH;
        r.fill_count = 7'(held);
        due_results.push_back(r);
      end
    endfunction

    function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = due_results.pop_front();
      cmp_field("out_byte", want.out_byte, got.out_byte);
      cmp_field("byte_valid", want.byte_valid, got.byte_valid);
      cmp_field("last", want.last, got.last);
      cmp_field("line_length", want.line_length, got.line_length);
      cmp_field("dropped", want.dropped, got.dropped);
      cmp_field("is_empty", want.is_empty, got.is_empty);
      cmp_field("is_full", want.is_full, got.is_full);
      cmp_field("fill_count", want.fill_count, got.fill_count);
    endfunction
  endclass

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_stall;
  item_t   item_bus;
  logic    result_valid;
  logic    result_stall;
  result_t result;

  ring_mirror book;
  int burst_left;
  bit hold_req;

  line_receive_ring_fifo u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item_bus),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // called at a falling edge; returns at the falling edge after acceptance, or later after a random idle gap
  task automatic offer(input action_t act, input logic [7:0] b, input logic [6:0] room);
    item_bus.action = act;
    item_bus.in_byte = b;
    item_bus.line_room = room;
    item_valid = 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    book.accept_item(item_bus);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      item_valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    end
  endtask

  task automatic wait_drained();
    item_valid = 1'b0;
    while (book.due_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == NEWLINE) b = 8'h0B;
    return b;
  endfunction

  // receiver stall patterns
  initial begin
    int hold_left;
    int phase_left;
    int stall_mode;
    logic [7:0] pat;
    int pat_idx;
    hold_left = 0;
    phase_left = 0;
    stall_mode = 0;
    pat = 8'h00;
    pat_idx = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = 300;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        result_stall = 1'b1;
        hold_left--;
      end else begin
        if (phase_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          phase_left = $urandom_range(20, 80);
          pat = 8'($urandom_range(0, 255));
        end
        phase_left--;
        case (stall_mode)
          0: result_stall = 1'b0;
          1: result_stall = $urandom_range(0, 99) < 35;
          default: begin
            result_stall = pat[pat_idx];
            pat_idx = (pat_idx + 1) % 8;
          end
        endcase
      end
    end
  end

  // result monitor
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) book.check_result(result);
    end
  end

  initial begin
    #50ms;
    $display("timeout waiting for results");
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int k;
    int n;
    int pick;
    int rand_sent;
    book = new();
    hold_req = 1'b0;
    burst_left = 0;
    item_valid = 1'b0;
    item_bus = '0;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed
    offer(ACT_POP, 8'h00, 7'd0);
    offer(ACT_LINE, 8'h00, 7'd10);
    offer(ACT_PUSH, 8'h00, 7'd0);
    offer(ACT_PUSH, 8'hFF, 7'd127);
    offer(ACT_LINE, 8'hFF, 7'd10);
    offer(ACT_PUSH, NEWLINE, 7'd0);
    offer(ACT_LINE, 8'h00, 7'd0);
    offer(ACT_LINE, 8'h00, 7'd1);
    offer(ACT_LINE, 8'h00, 7'd2);
    offer(ACT_LINE, 8'h00, 7'd127);
    offer(ACT_POP, 8'h00, 7'd0);
    offer(ACT_PUSH, 8'h55, 7'd0);
    offer(ACT_PUSH, 8'hAA, 7'd0);
    offer(ACT_PUSH, NEWLINE, 7'd0);
    offer(ACT_POP, 8'h00, 7'd0);
    offer(ACT_CLEAR, 8'hFF, 7'd127);
    offer(ACT_POP, 8'h00, 7'd0);
    offer(ACT_PUSH, NEWLINE, 7'd0);
    offer(ACT_LINE, 8'h00, 7'd65);

    // fill past capacity while the receiver holds off, then drain a full line
    wait_drained();
    offer(ACT_CLEAR, 8'h00, 7'd0);
    hold_req = 1'b1;
    for (k = 0; k < 66; k++) offer(ACT_PUSH, plain_byte(), 7'd0);
    offer(ACT_LINE, 8'h00, 7'd127);
    for (k = 0; k < 8; k++) offer(ACT_PUSH, plain_byte(), 7'd0);
    offer(ACT_PUSH, NEWLINE, 7'd0);
    offer(ACT_LINE, 8'h00, 7'd65);

    // random
    rand_sent = 0;
    while (rand_sent < 24) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        n = $urandom_range(0, 8);
        for (k = 0; k < n; k++) offer(ACT_PUSH, 8'($urandom_range(0, 255)), 7'd0);
        if ($urandom_range(0, 4) != 0) begin
          offer(ACT_PUSH, NEWLINE, 7'($urandom_range(0, 127)));
          n++;
        end
        if ($urandom_range(0, 4) != 0)
          offer(ACT_LINE, 8'($urandom_range(0, 255)), 7'($urandom_range(2, 16)));
        else
          offer(ACT_LINE, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
        rand_sent += n + 1;
      end else if (pick < 60) begin
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++) offer(ACT_POP, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
        rand_sent += n;
      end else if (pick < 68) begin
        offer(ACT_CLEAR, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
        rand_sent++;
      end else begin
        offer(action_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
              7'($urandom_range(0, 127)));
        rand_sent++;
      end
    end

    item_valid = 1'b0;
    while (book.due_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (book.errors == 0 && book.due_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (book.due_results.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, book.due_results.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/lrf_pkg.sv
rtl/lrf_ram.sv
rtl/lrf_datapath.sv
rtl/lrf_ctrl.sv
rtl/line_receive_ring_fifo.sv
rtl/lrf_checker.sv
tb/sv/testbench.sv
